// ===== hw/rtl/dual_led_ramp_pattern_sequencer_top_defines.svh =====
// assertion macros for the dual led ramp pattern sequencer
`ifndef DUAL_LED_RAMP_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define DUAL_LED_RAMP_PATTERN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DLRPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dlrps assertion failed");
`define DLRPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlrps assertion failed");
`else
`define DLRPS_ASSERT(lbl, prop)
`define DLRPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/dlrps_pkg.sv =====
// package with types, constants and pattern tables of the led ramp sequencer
package dlrps_pkg;

  localparam int unsigned NUM_PATTERNS  = 7;
  localparam int unsigned MAX_FRAGMENTS = 2;

  localparam int unsigned PAT_W  = 3;
  localparam int unsigned FRAG_W = 1;
  localparam int unsigned CNT_W  = 2;

  localparam logic [7:0] RESET_LEVEL   = 8'd64;
  localparam logic [7:0] RESET_LOCKOUT = 8'd60;

  // configuration register indexes
  localparam logic CFG_START_PATTERN  = 1'b0;
  localparam logic CFG_LOCKOUT_FRAMES = 1'b1;

  typedef struct packed {
    logic [7:0] len;
    logic [7:0] init_a;
    logic [7:0] inc_a;
    logic [7:0] init_b;
    logic [7:0] inc_b;
  } frag_t;

  // fragment table, increments 254 and 255 act as -2 and -1 modulo 256
  function automatic frag_t get_frag(input logic [PAT_W-1:0] p, input logic [FRAG_W-1:0] f);
    frag_t r;
    case ({p, f})
      4'b000_0: r = '{8'd0,  8'd64, 8'd0,   8'd64, 8'd0};
      4'b001_0: r = '{8'd32, 8'd0,  8'd2,   8'd64, 8'd254};
      4'b001_1: r = '{8'd32, 8'd64, 8'd254, 8'd0,  8'd2};
      4'b010_0: r = '{8'd32, 8'd0,  8'd2,   8'd0,  8'd2};
      4'b010_1: r = '{8'd32, 8'd64, 8'd254, 8'd64, 8'd254};
      4'b011_0: r = '{8'd32, 8'd32, 8'd255, 8'd64, 8'd255};
      4'b011_1: r = '{8'd32, 8'd64, 8'd255, 8'd32, 8'd255};
      4'b100_0: r = '{8'd64, 8'd64, 8'd255, 8'd64, 8'd255};
      4'b101_0: r = '{8'd32, 8'd0,  8'd0,   8'd64, 8'd0};
      4'b101_1: r = '{8'd32, 8'd64, 8'd0,   8'd0,  8'd0};
      4'b110_0: r = '{8'd32, 8'd64, 8'd0,   8'd64, 8'd0};
      4'b110_1: r = '{8'd32, 8'd0,  8'd0,   8'd0,  8'd0};
      default:  r = '{8'd0,  8'd0,  8'd0,   8'd0,  8'd0};
    endcase
    return r;
  endfunction

  // fragments used by a pattern, already limited to MAX_FRAGMENTS
  function automatic logic [CNT_W-1:0] frag_count(input logic [PAT_W-1:0] p);
    logic [CNT_W-1:0] n;
    case (p)
      3'd0:    n = 2'd1;
      3'd1:    n = 2'd2;
      3'd2:    n = 2'd2;
      3'd3:    n = 2'd2;
      3'd4:    n = 2'd1;
      3'd5:    n = 2'd2;
      3'd6:    n = 2'd2;
      default: n = 2'd1;
    endcase
    if (n > CNT_W'(MAX_FRAGMENTS)) begin
      n = CNT_W'(MAX_FRAGMENTS);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/dual_led_ramp_pattern_sequencer_top.sv =====
// top level of the dual led ramp pattern sequencer
//
// Each input item is one frame tick carrying the button state. The block
// answers with one item holding the two channel levels from before the tick,
// the pattern in use after it and a flag that asks for the pattern index to
// be stored. The tick is computed in a single pass
// of table lookups, 8-bit adds and compares from the state registers into the
// result register, so a new item is accepted every cycle while the result
// register is empty or being taken. Config writes are always ready; writing
// start_pattern restarts at that pattern (a low three-bit value of 7 selects 0)
// without touching the lockout counter, writing lockout_frames takes effect at
// the next accepted press. Reset state is pattern 0, levels 64, lockout 60.
`include "dual_led_ramp_pattern_sequencer_top_defines.svh"

module dual_led_ramp_pattern_sequencer_top
  import dlrps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // frame tick items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             button_pressed_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       level_a_o,
  output logic [7:0]       level_b_o,
  output logic [PAT_W-1:0] active_pattern_o,
  output logic             pattern_saved_o,
  // register writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i
);

  // configuration registers
  logic [PAT_W-1:0]  start_pattern_q, start_pattern_d;
  logic [7:0]        lockout_frames_q, lockout_frames_d;

  // sequencer state
  logic [PAT_W-1:0]  pattern_sel_q, pattern_sel_d;
  logic [FRAG_W-1:0] fragment_sel_q, fragment_sel_d;
  logic [7:0]        frames_left_q, frames_left_d;
  logic [7:0]        value_a_q, value_a_d;
  logic [7:0]        value_b_q, value_b_d;
  logic [7:0]        lockout_left_q, lockout_left_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        level_a_q, level_a_d;
  logic [7:0]        level_b_q, level_b_d;
  logic [PAT_W-1:0]  active_q, active_d;
  logic              saved_q, saved_d;

  logic in_acc, cfg_acc;

  // result register frees up in the same cycle it is read
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_comb begin
    frag_t             cur, nxt, rst_frag;
    logic [PAT_W-1:0]  psel, rst_psel;
    logic [FRAG_W-1:0] fsel;
    logic [CNT_W-1:0]  next_f;
    logic [7:0]        fl, va, vb, lo;
    logic              saved;

    start_pattern_d  = start_pattern_q;
    lockout_frames_d = lockout_frames_q;
    pattern_sel_d    = pattern_sel_q;
    fragment_sel_d   = fragment_sel_q;
    frames_left_d    = frames_left_q;
    value_a_d        = value_a_q;
    value_b_d        = value_b_q;
    lockout_left_d   = lockout_left_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    level_a_d        = level_a_q;
    level_b_d        = level_b_q;
    active_d         = active_q;
    saved_d          = saved_q;

    // frame tick: ramp first, then press handling, then fragment handover
    cur    = get_frag(pattern_sel_q, fragment_sel_q);
    fl     = frames_left_q - 8'd1;
    va     = value_a_q + cur.inc_a;
    vb     = value_b_q + cur.inc_b;
    lo     = lockout_left_q;
    psel   = pattern_sel_q;
    fsel   = fragment_sel_q;
    next_f = '0;
    saved  = 1'b0;

    if (lockout_left_q != 8'd0) begin
      lo = lockout_left_q - 8'd1;
    end else if (button_pressed_i) begin
      lo    = lockout_frames_q;
      psel  = (pattern_sel_q >= PAT_W'(NUM_PATTERNS - 1)) ? '0 : pattern_sel_q + PAT_W'(1);
      fsel  = '0;
      nxt   = get_frag(psel, fsel);
      fl    = nxt.len;
      va    = nxt.init_a;
      vb    = nxt.init_b;
      saved = 1'b1;
    end

    nxt = get_frag(psel, fsel);
    if (fl == 8'd0 && nxt.len != 8'd0) begin
      // finite fragment ran out, wrap within the pattern
      next_f = CNT_W'(fsel) + CNT_W'(1);
      if (next_f >= frag_count(psel)) begin
        next_f = '0;
      end
      fsel = next_f[FRAG_W-1:0];
      nxt  = get_frag(psel, fsel);
      fl   = nxt.len;
      va   = nxt.init_a;
      vb   = nxt.init_b;
    end

    if (in_acc) begin
      out_valid_d    = 1'b1;
      level_a_d      = value_a_q;
      level_b_d      = value_b_q;
      active_d       = psel;
      saved_d        = saved;
      pattern_sel_d  = psel;
      fragment_sel_d = fsel;
      frames_left_d  = fl;
      value_a_d      = va;
      value_b_d      = vb;
      lockout_left_d = lo;
    end

    // register writes, to be issued only while idle; the block does not enforce this
    rst_psel = (cfg_data_i[PAT_W-1:0] >= PAT_W'(NUM_PATTERNS)) ? '0 : cfg_data_i[PAT_W-1:0];
    rst_frag = get_frag(rst_psel, '0);
    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_START_PATTERN: begin
          start_pattern_d = cfg_data_i[PAT_W-1:0];
          pattern_sel_d   = rst_psel;
          fragment_sel_d  = '0;
          frames_left_d   = rst_frag.len;
          value_a_d       = rst_frag.init_a;
          value_b_d       = rst_frag.init_b;
        end
        CFG_LOCKOUT_FRAMES: begin
          lockout_frames_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pattern_q  <= '0;
      lockout_frames_q <= RESET_LOCKOUT;
      pattern_sel_q    <= '0;
      fragment_sel_q   <= '0;
      frames_left_q    <= 8'd0;
      value_a_q        <= RESET_LEVEL;
      value_b_q        <= RESET_LEVEL;
      lockout_left_q   <= RESET_LOCKOUT;
      out_valid_q      <= 1'b0;
    end else begin
      start_pattern_q  <= start_pattern_d;
      lockout_frames_q <= lockout_frames_d;
      pattern_sel_q    <= pattern_sel_d;
      fragment_sel_q   <= fragment_sel_d;
      frames_left_q    <= frames_left_d;
      value_a_q        <= value_a_d;
      value_b_q        <= value_b_d;
      lockout_left_q   <= lockout_left_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // result payload, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    level_a_q <= level_a_d;
    level_b_q <= level_b_d;
    active_q  <= active_d;
    saved_q   <= saved_d;
  end

  assign out_valid_o      = out_valid_q;
  assign level_a_o        = level_a_q;
  assign level_b_o        = level_b_q;
  assign active_pattern_o = active_q;
  assign pattern_saved_o  = saved_q;

  // pattern index stays inside the table
  `DLRPS_ASSERT(a_pattern_range, pattern_sel_q < PAT_W'(NUM_PATTERNS))
  // second fragment only in two-fragment patterns
  `DLRPS_ASSERT(a_frag_legal, fragment_sel_q == '0 || frag_count(pattern_sel_q) == 2'd2)
  // a held result blocks new items
  `DLRPS_ASSERT(a_hold_blocks, !(out_valid_q && !out_ready_i) || !in_ready_o)
  // a press outside the lockout gives a saved flag
  `DLRPS_ASSERT_NEXT(a_press_saves, in_acc && button_pressed_i && lockout_left_q == 8'd0,
                     out_valid_q && saved_q)

endmodule
